[rtl/adts_frame_deframer_unit_defines.svh]
// assertion macros shared by the deframer checker
`ifndef ADTS_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define ADTS_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define AFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define AFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/afd_pkg.sv]
// types and constants of the adts frame deframer
package afd_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_SYNC2   = 2'd1,
      PH_HEADER  = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   // result kind
   typedef enum logic [1:0] {
      KIND_HEADER     = 2'd0,
      KIND_PAYLOAD    = 2'd1,
      KIND_BAD_LENGTH = 2'd2
   } kind_type;

   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [3:0]  SYNC_NIBBLE   = 4'hF;
   localparam logic [12:0] HDR_BYTES     = 13'd7;
   localparam logic [2:0]  HDR_COLLECT   = 3'd4;

   // one input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } item_type;

   // one result item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic [12:0] frame_length;
      logic [1:0]  profile;
      logic [3:0]  rate_index;
      logic [2:0]  channel_config;
      logic        frame_end;
      logic        truncated;
   } result_type;

endpackage

[rtl/afd_in_stage.sv]
// input register of the deframer
module afd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  afd_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output afd_pkg::item_type item
);
   import afd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // register is free when empty or being drained this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = req_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload loads on every accepted item
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

[rtl/afd_parser.sv]
// sync hunt, header collection and payload count
module afd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                enable,
   input  afd_pkg::item_type   item,
   output logic                res_valid,
   output afd_pkg::result_type res
);
   import afd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [31:0] header_store_ff, header_store_in;
   logic [12:0] payload_left_ff, payload_left_in;

   logic [7:0]  b2, b3, b4, b5;
   logic [12:0] len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         header_count_ff <= 3'd0;
         header_store_ff <= 32'd0;
         payload_left_ff <= 13'd0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         header_store_ff <= header_store_in;
         payload_left_ff <= payload_left_in;
      end
   end

   // header fields from stored bytes two to five
   assign b2  = header_store_ff[31:24];
   assign b3  = header_store_ff[23:16];
   assign b4  = header_store_ff[15:8];
   assign b5  = header_store_ff[7:0];
   assign len = {b3[1:0], b4, b5[7:5]};

   // next state and result
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      header_store_in = header_store_ff;
      payload_left_in = payload_left_ff;
      res_valid       = 1'b0;
      res             = '0;
      if (step && enable) begin
         case (phase_ff)
            PH_HUNT: begin
               if (!item.end_of_buffer && item.data_byte == SYNC_BYTE) begin
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (!item.end_of_buffer && item.data_byte[7:4] == SYNC_NIBBLE) begin
                  phase_in        = PH_HEADER;
                  header_count_in = 3'd0;
                  header_store_in = 32'd0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_HEADER: begin
               if (header_count_ff < HDR_COLLECT) begin
                  header_store_in = {header_store_ff[23:0], item.data_byte};
                  header_count_in = header_count_ff + 3'd1;
                  if (item.end_of_buffer) begin
                     phase_in = PH_HUNT;
                  end
               end else begin
                  // seventh header byte: report the header
                  res_valid          = 1'b1;
                  res.frame_length   = len;
                  res.profile        = b2[7:6];
                  res.rate_index     = b2[5:2];
                  res.channel_config = {b2[0], b3[7:6]};
                  res.kind           = KIND_HEADER;
                  header_count_in    = 3'd0;
                  if (len < HDR_BYTES) begin
                     res.kind = KIND_BAD_LENGTH;
                     phase_in = PH_HUNT;
                  end else if (len == HDR_BYTES) begin
                     phase_in = PH_HUNT;
                  end else if (item.end_of_buffer) begin
                     res.truncated = 1'b1;
                     phase_in      = PH_HUNT;
                  end else begin
                     payload_left_in = len - HDR_BYTES;
                     phase_in        = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               res_valid        = 1'b1;
               res.kind         = KIND_PAYLOAD;
               res.payload_byte = item.data_byte;
               if (payload_left_ff <= 13'd1) begin
                  res.frame_end   = 1'b1;
                  payload_left_in = 13'd0;
                  phase_in        = PH_HUNT;
               end else if (item.end_of_buffer) begin
                  res.truncated   = 1'b1;
                  payload_left_in = 13'd0;
                  phase_in        = PH_HUNT;
               end else begin
                  payload_left_in = payload_left_ff - 13'd1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end
endmodule

[rtl/afd_out_stage.sv]
// result register of the deframer
module afd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                res_valid,
   input  afd_pkg::result_type res,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output afd_pkg::result_type rsp
);
   import afd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   // free when empty or being taken this cycle
   assign space    = !valid_ff || rsp_ready;
   assign valid_in = space ? (step && res_valid) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = res_ff;
endmodule

[rtl/adts_frame_deframer_unit.sv]
// top level of the adts frame deframer
// Takes one byte of an ADTS stream per cycle when not held by back-pressure
// and, once enabled, hunts for the 0xFF / 0xFx sync pair, gathers the rest of
// the seven-byte header, reports frame length, profile, rate index and channel
// configuration (kind 0, or kind 2 when the length is below seven), then passes
// the payload bytes through (kind 1) with tlast on the final one and a truncated
// flag when req_tlast ends the buffer early. One item is accepted every cycle
// while the result register has room. An accepted item is held in the input
// register, and its result is loaded into the result register once that has
// room; rsp_tvalid then rises. rsp_tready back-pressure reaches req_tready
// combinationally through those two stages. Items that cause no result are
// still consumed at full rate while the result register has room. With enable
// clear, items are taken and dropped.
module adts_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // payload_byte[7:0], frame_length[20:8], profile[22:21], rate_index[26:23],
   // channel_config[29:27], truncated[30], zero[31]
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // enable
);
   import afd_pkg::*;

   logic       enable_ff;
   item_type   req_item, item;
   logic       item_valid, step, space;
   logic       res_valid;
   result_type res, rsp;

   // enable register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_valid) begin
         enable_ff <= csr_data;
      end
   end

   assign req_item.data_byte     = req_tdata;
   assign req_item.end_of_buffer = req_tlast;
   assign step                   = item_valid && space;

   afd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   afd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .enable    (enable_ff),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   afd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .res_valid (res_valid),
      .res       (res),
      .space     (space),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // result packing
   assign rsp_tdata = {1'b0, rsp.truncated, rsp.channel_config, rsp.rate_index,
                       rsp.profile, rsp.frame_length, rsp.payload_byte};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.frame_end;
endmodule

[rtl/afd_checker.sv]
// port checker of the deframer and its bind
`include "adts_frame_deframer_unit_defines.svh"

module afd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import afd_pkg::*;

   // a stalled result item holds
   `AFD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")

   // frame end only on payload items
   `AFD_ASSERT_NOW(a_last_payload, rsp_tvalid && rsp_tlast, rsp_tuser == KIND_PAYLOAD, "frame end on non-payload item")

   // frame end and truncation exclude each other
   `AFD_ASSERT_NOW(a_end_trunc, rsp_tvalid && rsp_tlast, !rsp_tdata[30], "frame end with truncated set")

   // bad length items carry a length below the header size
   `AFD_ASSERT_NOW(a_bad_len, rsp_tvalid && rsp_tuser == KIND_BAD_LENGTH, rsp_tdata[20:8] < HDR_BYTES, "bad length item with valid length")
endmodule

bind adts_frame_deframer_unit afd_checker u_afd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[verif/adts_frame_deframer_unit_tb.sv]
// testbench for the adts frame deframer: directed rows, then random frames against a predictor
`timescale 1ns / 1ps

module adts_frame_deframer_unit_tb;
   import afd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_SLACK = 6;
   localparam int PHASE_ITEMS = 125;
   localparam int NUM_PHASES  = 6;

   // how a directed row is checked
   typedef enum {
      ROW_PREDICT,
      ROW_NONE,
      ROW_RESULT
   } row_mode_type;

   typedef struct {
      logic [7:0]   data;
      logic         eob;
      row_mode_type mode;
      result_type   want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // data_byte
   logic        req_tlast;   // end_of_buffer
   logic        rsp_tvalid;
   logic        rsp_tready;
   // payload_byte[7:0], frame_length[20:8], profile[22:21], rate_index[26:23],
   // channel_config[29:27], truncated[30], zero[31]
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;   // kind
   logic        rsp_tlast;   // frame_end
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;    // enable

   adts_frame_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // parser shadow state
   logic        enable_shadow;
   phase_type   hunt_phase;
   logic [2:0]  hdr_count;
   logic [31:0] hdr_bytes;
   logic [12:0] payload_left;

   result_type   pending_results[$];
   stim_row_type stim_rows[$];

   int fail_count;
   int cycle_count;
   int items_enabled;
   int idle_pct;
   bit quiet;
   int stall_left;
   int headers_seen;
   int payloads_seen;
   int bad_lengths_seen;
   int truncated_seen;
   int frame_ends_seen;

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // result-side back-pressure in random bursts
   always @(negedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic result_type mk_result(kind_type kind, logic [7:0] pbyte,
                                            logic [12:0] flen, logic [1:0] prof,
                                            logic [3:0] rate, logic [2:0] chan,
                                            logic fend, logic trunc);
      result_type r;
      r.kind           = kind;
      r.payload_byte   = pbyte;
      r.frame_length   = flen;
      r.profile        = prof;
      r.rate_index     = rate;
      r.channel_config = chan;
      r.frame_end      = fend;
      r.truncated      = trunc;
      return r;
   endfunction

   // deframer prediction for one accepted byte
   task automatic deframe_byte(input logic [7:0] b, input logic eob, output bit got,
                               output result_type r);
      logic [12:0] flen;
      got = 1'b0;
      r   = '0;
      if (!enable_shadow) return;
      case (hunt_phase)
         PH_HUNT: begin
            if (!eob && b == SYNC_BYTE) hunt_phase = PH_SYNC2;
         end
         PH_SYNC2: begin
            if (!eob && b[7:4] == SYNC_NIBBLE) begin
               hunt_phase = PH_HEADER;
               hdr_count  = '0;
               hdr_bytes  = '0;
            end else begin
               hunt_phase = PH_HUNT;
            end
         end
         PH_HEADER: begin
            if (hdr_count < HDR_COLLECT) begin
               hdr_bytes = {hdr_bytes[23:0], b};
               hdr_count = hdr_count + 3'd1;
               if (eob) hunt_phase = PH_HUNT;
            end else begin
               // seventh header byte: fields come from bytes two to five
               flen = {hdr_bytes[17:16], hdr_bytes[15:8], hdr_bytes[7:5]};
               got = 1'b1;
               r.frame_length   = flen;
               r.profile        = hdr_bytes[31:30];
               r.rate_index     = hdr_bytes[29:26];
               r.channel_config = {hdr_bytes[24], hdr_bytes[23:22]};
               hdr_count = '0;
               if (flen < HDR_BYTES) begin
                  r.kind     = KIND_BAD_LENGTH;
                  hunt_phase = PH_HUNT;
               end else if (flen == HDR_BYTES) begin
                  r.kind     = KIND_HEADER;
                  hunt_phase = PH_HUNT;
               end else if (eob) begin
                  r.kind      = KIND_HEADER;
                  r.truncated = 1'b1;
                  hunt_phase  = PH_HUNT;
               end else begin
                  r.kind       = KIND_HEADER;
                  payload_left = flen - HDR_BYTES;
                  hunt_phase   = PH_PAYLOAD;
               end
            end
         end
         default: begin
            // payload pass-through, final byte wins over buffer end
            got = 1'b1;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            if (payload_left <= 13'd1) begin
               r.frame_end  = 1'b1;
               payload_left = '0;
               hunt_phase   = PH_HUNT;
            end else if (eob) begin
               r.truncated  = 1'b1;
               payload_left = '0;
               hunt_phase   = PH_HUNT;
            end else begin
               payload_left = payload_left - 13'd1;
            end
         end
      endcase
   endtask

   // offer one byte, called and returning at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic eob, input row_mode_type mode,
                            input result_type want);
      bit         got;
      result_type r;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eob;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (enable_shadow) items_enabled++;
      deframe_byte(b, eob, got, r);
      if (mode == ROW_RESULT) pending_results = {pending_results, want};
      else if (mode == ROW_PREDICT && got) pending_results = {pending_results, r};
   endtask

   task automatic send_plain(input logic [7:0] b, input logic eob);
      send_byte(b, eob, ROW_PREDICT, '0);
   endtask

   // one random frame, noise burst or broken sync
   task automatic send_frame();
      int          pick;
      int          flen;
      int          total;
      int          cut;
      int          last;
      int          i;
      int          n;
      logic [12:0] len13;
      logic [7:0]  hdr[7];
      logic [7:0]  b;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         // well-formed frame, mostly short lengths
         n = $urandom_range(0, 99);
         if (n < 10) flen = $urandom_range(0, 6);
         else if (n < 15) flen = 7;
         else if (n < 95) flen = $urandom_range(8, 40);
         else flen = $urandom_range(41, 300);
         len13  = 13'(flen);
         hdr[0] = SYNC_BYTE;
         hdr[1] = ($urandom_range(0, 7) == 0) ? SYNC_BYTE
                                              : {SYNC_NIBBLE, 4'($urandom_range(0, 15))};
         hdr[2] = 8'($urandom);
         hdr[3] = {6'($urandom), len13[12:11]};
         hdr[4] = len13[10:3];
         hdr[5] = {len13[2:0], 5'($urandom)};
         hdr[6] = 8'($urandom);
         total  = 7 + ((flen > 7) ? flen - 7 : 0);
         // occasional early buffer end anywhere in the frame
         cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total;
         last = (cut < total) ? cut : total - 1;
         for (i = 0; i <= last; i++) begin
            b = (i < 7) ? hdr[i] : 8'($urandom);
            send_plain(b, (i == cut) || (i == total - 1 && $urandom_range(0, 3) == 0));
         end
      end else if (pick < 85) begin
         // noise, biased toward sync bytes
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++) begin
            b = ($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom);
            send_plain(b, $urandom_range(0, 9) == 0);
         end
      end else if (pick < 93) begin
         // failed second sync byte
         send_plain(SYNC_BYTE, 1'b0);
         send_plain({4'($urandom_range(0, 14)), 4'($urandom)}, $urandom_range(0, 3) == 0);
      end else begin
         // header cut short, next frame's sync lands inside it
         send_plain(SYNC_BYTE, 1'b0);
         send_plain({SYNC_NIBBLE, 4'($urandom)}, 1'b0);
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) send_plain(8'($urandom), 1'b0);
      end
   endtask

   // hold the sender until every expected item is back, then let the pipe empty
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_SLACK) @(negedge clock);
   endtask

   task automatic write_enable(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      enable_shadow = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_row(input logic [7:0] data, input logic eob, input row_mode_type mode,
                          input result_type want);
      stim_row_type row;
      row.data = data;
      row.eob  = eob;
      row.mode = mode;
      row.want = want;
      stim_rows = {stim_rows, row};
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // compare each accepted result item with the oldest expectation
   always @(posedge clock) begin : watch_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result item with none expected: tuser %0d tdata %h", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_tuser);
            check_field("payload_byte", want.payload_byte, rsp_tdata[7:0]);
            check_field("frame_length", want.frame_length, rsp_tdata[20:8]);
            check_field("profile", want.profile, rsp_tdata[22:21]);
            check_field("rate_index", want.rate_index, rsp_tdata[26:23]);
            check_field("channel_config", want.channel_config, rsp_tdata[29:27]);
            check_field("truncated", want.truncated, rsp_tdata[30]);
            check_field("frame_end", want.frame_end, rsp_tlast);
            case (want.kind)
               KIND_HEADER:     headers_seen++;
               KIND_PAYLOAD:    payloads_seen++;
               default:         bad_lengths_seen++;
            endcase
            if (want.truncated) truncated_seen++;
            if (want.frame_end) frame_ends_seen++;
         end
      end
   end

   initial begin : run_test
      int ph_i;
      int goal;
      int i;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b1;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      quiet = 1'b0;
      stall_left = 0;
      idle_pct = 20;
      fail_count = 0;
      cycle_count = 0;
      items_enabled = 0;
      headers_seen = 0;
      payloads_seen = 0;
      bad_lengths_seen = 0;
      truncated_seen = 0;
      frame_ends_seen = 0;
      enable_shadow = 1'b0;
      hunt_phase = PH_HUNT;
      hdr_count = '0;
      hdr_bytes = '0;
      payload_left = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // disabled after reset: traffic is dropped
      for (i = 0; i < 3; i++) send_frame();
      drain();
      write_enable(1'b1);

      // directed rows
      // buffer end while hunting, then a failed sync
      add_row(8'hFF, 1'b1, ROW_NONE, '0);
      add_row(8'hFF, 1'b0, ROW_NONE, '0);
      add_row(8'h0F, 1'b0, ROW_NONE, '0);
      // repeated sync byte, all-ones header fields, length nine
      add_row(8'hFF, 1'b0, ROW_NONE, '0);
      add_row(8'hFF, 1'b0, ROW_NONE, '0);
      add_row(8'hFD, 1'b0, ROW_PREDICT, '0);
      add_row(8'hC0, 1'b0, ROW_PREDICT, '0);
      add_row(8'h01, 1'b0, ROW_PREDICT, '0);
      add_row(8'h20, 1'b0, ROW_PREDICT, '0);
      add_row(8'hFC, 1'b0, ROW_RESULT,
              mk_result(KIND_HEADER, 8'h00, 13'd9, 2'd3, 4'd15, 3'd7, 1'b0, 1'b0));
      add_row(8'h00, 1'b0, ROW_RESULT,
              mk_result(KIND_PAYLOAD, 8'h00, '0, '0, '0, '0, 1'b0, 1'b0));
      // final payload byte with buffer end: frame end, not truncated
      add_row(8'hFF, 1'b1, ROW_RESULT,
              mk_result(KIND_PAYLOAD, 8'hFF, '0, '0, '0, '0, 1'b1, 1'b0));
      // largest length, buffer ends on the seventh header byte
      add_row(8'hFF, 1'b0, ROW_NONE, '0);
      add_row(8'hF1, 1'b0, ROW_NONE, '0);
      add_row(8'h00, 1'b0, ROW_PREDICT, '0);
      add_row(8'h03, 1'b0, ROW_PREDICT, '0);
      add_row(8'hFF, 1'b0, ROW_PREDICT, '0);
      add_row(8'hE0, 1'b0, ROW_PREDICT, '0);
      add_row(8'hFF, 1'b1, ROW_RESULT,
              mk_result(KIND_HEADER, 8'h00, 13'd8191, '0, '0, '0, 1'b0, 1'b1));
      // zero length is flagged
      add_row(8'hFF, 1'b0, ROW_NONE, '0);
      add_row(8'hF0, 1'b0, ROW_NONE, '0);
      add_row(8'h00, 1'b0, ROW_PREDICT, '0);
      add_row(8'h00, 1'b0, ROW_PREDICT, '0);
      add_row(8'h00, 1'b0, ROW_PREDICT, '0);
      add_row(8'h00, 1'b0, ROW_PREDICT, '0);
      add_row(8'h00, 1'b0, ROW_RESULT,
              mk_result(KIND_BAD_LENGTH, 8'h00, '0, '0, '0, '0, 1'b0, 1'b0));
      foreach (stim_rows[j]) send_byte(stim_rows[j].data, stim_rows[j].eob, stim_rows[j].mode,
                                       stim_rows[j].want);
      drain();

      // disable mid-stream, state must hold across the gap
      write_enable(1'b0);
      for (i = 0; i < 2; i++) send_frame();
      drain();
      write_enable(1'b1);

      // random phases with varying idle rates, the last one without idling
      items_enabled = 0;
      for (ph_i = 0; ph_i < NUM_PHASES; ph_i++) begin
         case (ph_i)
            0:       idle_pct = 30;
            1:       idle_pct = 0;
            2:       idle_pct = 15;
            3:       idle_pct = 50;
            4:       idle_pct = 20;
            default: idle_pct = 0;
         endcase
         quiet = (ph_i == NUM_PHASES - 1);
         goal = items_enabled + PHASE_ITEMS;
         while (items_enabled < goal) send_frame();
         drain();
         if (ph_i % 2 == 1 && ph_i != NUM_PHASES - 1) begin
            write_enable(1'b0);
            send_frame();
            drain();
            write_enable(1'b1);
         end
      end
      drain();

      $display("covered %0d header, %0d payload and %0d bad-length items",
               headers_seen, payloads_seen, bad_lengths_seen);
      $display("frame ends %0d, truncated frames %0d, mismatches %0d",
               frame_ends_seen, truncated_seen, fail_count);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
